// ----- hdl/mdpu_pkg.sv -----
// Package for the Mersenne digit pack/unpack block.
// Holds shared types, register codes, reset constants and the digit mask helper.
// No dependencies.
package mdpu_pkg;

  // Word geometry and per-item result limit.
  localparam int unsigned WordBits   = 32;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned DivSteps   = 32;

  localparam logic [5:0] WidthFull = 6'd32;

  // Register reset values and the digit geometry they imply (1 / 1).
  localparam logic [31:0] RstExponent   = 32'd1;
  localparam logic [28:0] RstDigitCount = 29'd1;
  localparam logic [27:0] RstWordTotal  = 28'd1;
  localparam logic        RstDirection  = 1'b0;
  localparam logic [5:0]  RstBaseWidth  = 6'd1;
  localparam logic [28:0] RstWidthStep  = 29'd1;

  localparam int unsigned CfgIndexWidth = 8;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_EXPONENT    = 8'd0,
    CFG_DIGIT_COUNT = 8'd1,
    CFG_WORD_TOTAL  = 8'd2,
    CFG_DIRECTION   = 8'd3
  } cfg_index_e;

  // Kind of a queued item, fixed by the direction when it is accepted.
  typedef enum logic {
    KIND_WORD  = 1'b0,
    KIND_DIGIT = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_UNPACK,
    ENG_PACK_DIGIT,
    ENG_PACK_PAD
  } eng_state_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [31:0] data;
    logic [5:0]  width;
    logic        last;
  } item_t;

  // Configuration and derived digit geometry, as seen by the datapath.
  typedef struct packed {
    logic [28:0] n_eff;
    logic [27:0] word_total;
    logic        direction;
    logic [5:0]  base_width;
    logic [28:0] width_step;
    logic        busy;
  } cfg_t;

  typedef struct packed {
    logic [31:0] data;
    logic [5:0]  width;
    logic        err;
    logic        last;
  } result_t;

  // Mask of the low w bits of a word; widths of 32 and above give all ones.
  function automatic logic [31:0] low_mask(input logic [5:0] w);
    logic [31:0] m;
    if (w >= WidthFull) begin
      m = '1;
    end else begin
      m = (32'd1 << w) - 32'd1;
    end
    return m;
  endfunction

endpackage

// ----- hdl/mdpu_cfg.sv -----
// Configuration registers and digit geometry unit for the digit pack/unpack block.
// Derives base width and width step with a one-bit-per-cycle restoring divider.
// Depends on mdpu_pkg.
module mdpu_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mdpu_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  output mdpu_pkg::cfg_t                      cfg_o,
  output logic                                restart_o
);

  logic [31:0] exp_q, exp_d;
  logic [28:0] dc_q, dc_d;
  logic [27:0] wt_q, wt_d;
  logic        dir_q, dir_d;
  logic [5:0]  base_q, base_d;
  logic [28:0] step_q, step_d;

  mdpu_pkg::div_state_e div_state_q, div_state_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [28:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvd_q, dvd_d;

  logic        known;
  logic        start;
  logic [28:0] n_eff;
  logic [29:0] trial;
  logic        trial_ge;

  // Writes are always taken; a write to a known register restarts the divider.
  assign cfg_ready_o = 1'b1;

  assign n_eff = (dc_q == '0) ? 29'd1 : dc_q;

  // Register write decode.
  always_comb begin
    exp_d = exp_q;
    dc_d  = dc_q;
    wt_d  = wt_q;
    dir_d = dir_q;
    known = 1'b1;
    unique case (cfg_index_i)
      mdpu_pkg::CFG_EXPONENT:    exp_d = cfg_data_i;
      mdpu_pkg::CFG_DIGIT_COUNT: dc_d  = cfg_data_i[28:0];
      mdpu_pkg::CFG_WORD_TOTAL:  wt_d  = cfg_data_i[27:0];
      mdpu_pkg::CFG_DIRECTION:   dir_d = cfg_data_i[0];
      default:                   known = 1'b0;
    endcase
    if (!cfg_valid_i || !known) begin
      exp_d = exp_q;
      dc_d  = dc_q;
      wt_d  = wt_q;
      dir_d = dir_q;
    end
  end

  assign start     = cfg_valid_i && known;
  assign restart_o = start;

  // One quotient bit per cycle: shift in a dividend bit, subtract when it fits.
  assign trial    = {rem_q, dvd_q[31]};
  assign trial_ge = trial >= {1'b0, n_eff};

  always_comb begin
    div_state_d = div_state_q;
    div_cnt_d   = div_cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvd_d       = dvd_q;
    base_d      = base_q;
    step_d      = step_q;
    unique case (div_state_q)
      mdpu_pkg::DIV_IDLE: begin
      end
      mdpu_pkg::DIV_RUN: begin
        rem_d     = trial_ge ? 29'(trial - {1'b0, n_eff}) : trial[28:0];
        quo_d     = {quo_q[30:0], trial_ge};
        dvd_d     = {dvd_q[30:0], 1'b0};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'(mdpu_pkg::DivSteps - 1)) begin
          div_state_d = mdpu_pkg::DIV_DONE;
        end
      end
      mdpu_pkg::DIV_DONE: begin
        base_d      = (quo_q > 32'(mdpu_pkg::WordBits)) ? mdpu_pkg::WidthFull : quo_q[5:0];
        step_d      = n_eff - rem_q;
        div_state_d = mdpu_pkg::DIV_IDLE;
      end
      default: div_state_d = mdpu_pkg::DIV_IDLE;
    endcase
    // A new write starts the division over with the updated registers.
    if (start) begin
      div_state_d = mdpu_pkg::DIV_RUN;
      div_cnt_d   = '0;
      rem_d       = '0;
      quo_d       = '0;
      dvd_d       = exp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= mdpu_pkg::RstExponent;
      dc_q        <= mdpu_pkg::RstDigitCount;
      wt_q        <= mdpu_pkg::RstWordTotal;
      dir_q       <= mdpu_pkg::RstDirection;
      base_q      <= mdpu_pkg::RstBaseWidth;
      step_q      <= mdpu_pkg::RstWidthStep;
      div_state_q <= mdpu_pkg::DIV_IDLE;
      div_cnt_q   <= '0;
    end else begin
      exp_q       <= exp_d;
      dc_q        <= dc_d;
      wt_q        <= wt_d;
      dir_q       <= dir_d;
      base_q      <= base_d;
      step_q      <= step_d;
      div_state_q <= div_state_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // Divider datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvd_q <= dvd_d;
  end

  assign cfg_o.n_eff      = n_eff;
  assign cfg_o.word_total = wt_q;
  assign cfg_o.direction  = dir_q;
  assign cfg_o.base_width = base_q;
  assign cfg_o.width_step = step_q;
  assign cfg_o.busy       = (div_state_q != mdpu_pkg::DIV_IDLE);

endmodule

// ----- hdl/mdpu_front.sv -----
// Front end of the digit pack/unpack block: accepts items, tags them as
// words or digits and holds them in a short queue for the engine.
// Depends on mdpu_pkg.
module mdpu_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          data_in_i,
  input  logic [5:0]           width_in_i,
  input  logic                 last_in_i,
  input  logic                 direction_i,
  input  logic                 hold_i,
  output logic                 head_valid_o,
  output mdpu_pkg::item_t      head_o,
  input  logic                 pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  mdpu_pkg::item_t entry_q [QueueDepth];
  mdpu_pkg::item_t new_item;

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  // Classify the item by the current direction.
  always_comb begin
    new_item.kind  = direction_i ? mdpu_pkg::KIND_DIGIT : mdpu_pkg::KIND_WORD;
    new_item.data  = data_in_i;
    new_item.width = width_in_i;
    new_item.last  = last_in_i;
  end

  assign in_ready_o   = !hold_i && (count_q != CntW'(QueueDepth));
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ----- hdl/mdpu_engine.sv -----
// Back end of the digit pack/unpack block: bit buffer, digit width tracking
// and result sequencing, one result per cycle into an output register unless it is stalled.
// Depends on mdpu_pkg.
module mdpu_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mdpu_pkg::cfg_t     cfg_i,
  input  logic               restart_i,
  input  logic               item_valid_i,
  input  mdpu_pkg::item_t    item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mdpu_pkg::result_t  out_o
);

  mdpu_pkg::eng_state_e state_q, state_d;
  logic [63:0] buf_q, buf_d;
  logic [6:0]  fill_q, fill_d;
  logic [28:0] acc_q, acc_d;
  logic [28:0] didx_q, didx_d;
  logic [27:0] wdone_q, wdone_d;
  logic [6:0]  cnt_q, cnt_d;
  mdpu_pkg::item_t   item_q, item_d;
  logic              out_valid_q, out_valid_d;
  mdpu_pkg::result_t out_q, out_d;

  logic [29:0] acc_sum;
  logic        wide_digit;
  logic [28:0] acc_adv;
  logic [6:0]  w_sum;
  logic [5:0]  cur_w;
  logic        digits_left;
  logic        last_digit;
  logic        words_left;
  logic        final_word;
  logic        cap_left;
  logic        cap_final;
  logic        slot_free;
  logic [31:0] u_value;
  logic [6:0]  u_fill;
  logic        u_cont;
  logic [63:0] p_app;
  logic [6:0]  p_fill;
  logic        p_full;
  logic        p_emit;

  // Digit width from the running modular accumulator.
  assign acc_sum    = {1'b0, acc_q} + {1'b0, cfg_i.width_step};
  assign wide_digit = acc_sum < {1'b0, cfg_i.n_eff};
  assign acc_adv    = wide_digit ? acc_sum[28:0] : 29'(acc_sum - {1'b0, cfg_i.n_eff});
  assign w_sum      = {1'b0, cfg_i.base_width} + {6'd0, wide_digit};
  assign cur_w      = (w_sum > 7'(mdpu_pkg::WordBits)) ? mdpu_pkg::WidthFull : w_sum[5:0];

  // Progress through the residue and through this item's results.
  assign digits_left = didx_q < cfg_i.n_eff;
  assign last_digit  = didx_q == (cfg_i.n_eff - 29'd1);
  assign words_left  = wdone_q < cfg_i.word_total;
  assign final_word  = ({1'b0, wdone_q} + 29'd1) == {1'b0, cfg_i.word_total};
  assign cap_left    = cnt_q != 7'(mdpu_pkg::MaxResults);
  assign cap_final   = cnt_q == 7'(mdpu_pkg::MaxResults - 1);
  assign slot_free   = !out_valid_q || out_ready_i;

  // Unpack: take the next digit off the bottom of the buffer.
  assign u_value = buf_q[31:0] & mdpu_pkg::low_mask(cur_w);
  assign u_fill  = (fill_q >= {1'b0, cur_w}) ? fill_q - {1'b0, cur_w} : '0;
  assign u_cont  = cap_left && digits_left && ((fill_q >= {1'b0, cur_w}) || item_q.last);

  // Pack: append the checked digit above the bits already held.
  assign p_app  = buf_q | ({32'd0, item_q.data & mdpu_pkg::low_mask(cur_w)} << fill_q[5:0]);
  assign p_fill = fill_q + {1'b0, cur_w};
  assign p_full = p_fill >= 7'(mdpu_pkg::WordBits);
  assign p_emit = p_full && words_left;

  // Sequencer: one step of the current item, then take the next item.
  always_comb begin
    logic [31:0] word_v;
    logic [7:0]  fill_ext_v;
    logic        done_v;
    logic        clear_v;

    state_d     = state_q;
    buf_d       = buf_q;
    fill_d      = fill_q;
    acc_d       = acc_q;
    didx_d      = didx_q;
    wdone_d     = wdone_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    item_pop_o  = 1'b0;
    word_v      = '0;
    fill_ext_v  = '0;
    done_v      = 1'b0;
    clear_v     = 1'b0;

    unique case (state_q)
      mdpu_pkg::ENG_IDLE: begin
        done_v = 1'b1;
      end

      mdpu_pkg::ENG_UNPACK: begin
        if (u_cont) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_d.data  = u_value;
            out_d.width = cur_w;
            out_d.err   = 1'b0;
            out_d.last  = last_digit || (item_q.last && cap_final);
            buf_d       = buf_q >> cur_w;
            fill_d      = u_fill;
            acc_d       = acc_adv;
            didx_d      = didx_q + 29'd1;
            cnt_d       = cnt_q + 7'd1;
          end
        end else begin
          done_v  = 1'b1;
          clear_v = item_q.last;
        end
      end

      mdpu_pkg::ENG_PACK_DIGIT: begin
        if (digits_left) begin
          if (item_q.width != cur_w) begin
            // Width mismatch: one error result, then the residue starts over.
            if (slot_free) begin
              out_valid_d = 1'b1;
              out_d.data  = '0;
              out_d.width = mdpu_pkg::WidthFull;
              out_d.err   = 1'b1;
              out_d.last  = 1'b1;
              done_v      = 1'b1;
              clear_v     = 1'b1;
            end
          end else if (!p_emit || slot_free) begin
            if (p_emit) begin
              out_valid_d = 1'b1;
              out_d.data  = p_app[31:0];
              out_d.width = mdpu_pkg::WidthFull;
              out_d.err   = 1'b0;
              out_d.last  = item_q.last && final_word;
              wdone_d     = wdone_q + 28'd1;
              cnt_d       = cnt_q + 7'd1;
            end
            if (p_full) begin
              buf_d  = p_app >> mdpu_pkg::WordBits;
              fill_d = p_fill - 7'(mdpu_pkg::WordBits);
            end else begin
              buf_d  = p_app;
              fill_d = p_fill;
            end
            acc_d  = acc_adv;
            didx_d = didx_q + 29'd1;
            if (item_q.last) begin
              state_d = mdpu_pkg::ENG_PACK_PAD;
            end else begin
              done_v = 1'b1;
            end
          end
        end else if (item_q.last) begin
          state_d = mdpu_pkg::ENG_PACK_PAD;
        end else begin
          done_v = 1'b1;
        end
      end

      mdpu_pkg::ENG_PACK_PAD: begin
        // Flush the partial word, then zero words up to the word total or the result limit.
        if (words_left && cap_left) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_d.data  = buf_q[31:0];
            out_d.width = mdpu_pkg::WidthFull;
            out_d.err   = 1'b0;
            out_d.last  = final_word || cap_final;
            buf_d       = buf_q >> mdpu_pkg::WordBits;
            fill_d      = '0;
            wdone_d     = wdone_q + 28'd1;
            cnt_d       = cnt_q + 7'd1;
          end
        end else begin
          done_v  = 1'b1;
          clear_v = 1'b1;
        end
      end

      default: state_d = mdpu_pkg::ENG_IDLE;
    endcase

    // End of residue: back to the first digit and word.
    if (clear_v) begin
      buf_d   = '0;
      fill_d  = '0;
      acc_d   = '0;
      didx_d  = '0;
      wdone_d = '0;
    end

    // Take the next item; a word is appended to the buffer right away.
    if (done_v) begin
      state_d = mdpu_pkg::ENG_IDLE;
      if (item_valid_i) begin
        item_pop_o = 1'b1;
        item_d     = item_i;
        cnt_d      = '0;
        if (item_i.kind == mdpu_pkg::KIND_DIGIT) begin
          state_d = mdpu_pkg::ENG_PACK_DIGIT;
        end else begin
          state_d = mdpu_pkg::ENG_UNPACK;
          if (wdone_d < cfg_i.word_total) begin
            word_v  = item_i.data;
            wdone_d = wdone_d + 28'd1;
          end
          if (didx_d < cfg_i.n_eff) begin
            if (fill_d < 7'd64) begin
              buf_d = buf_d | ({32'd0, word_v} << fill_d[5:0]);
            end
            fill_ext_v = {1'b0, fill_d} + 8'(mdpu_pkg::WordBits);
            fill_d     = (fill_ext_v > 8'd64) ? 7'd64 : fill_ext_v[6:0];
          end
        end
      end
    end

    // A register write drops the residue in progress.
    if (restart_i) begin
      buf_d   = '0;
      fill_d  = '0;
      acc_d   = '0;
      didx_d  = '0;
      wdone_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdpu_pkg::ENG_IDLE;
      buf_q       <= '0;
      fill_q      <= '0;
      acc_q       <= '0;
      didx_q      <= '0;
      wdone_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_q       <= buf_d;
      fill_q      <= fill_d;
      acc_q       <= acc_d;
      didx_q      <= didx_d;
      wdone_q     <= wdone_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Current item and result payload.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- hdl/mersenne_digit_pack_unpack.sv -----
// Channel  Dir  Handshake                    Payload
// in       in   in_valid_i / in_ready_o      data_in_i, width_in_i, last_in_i
// out      out  out_valid_o / out_ready_i    data_out_o, width_out_o, width_error_o, last_out_o
// cfg      in   cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// Unpack takes each word into the buffer and then gives out its digits one at a time;
// the step that finds no further complete digit also takes the next word.
// Pack takes the digits one at a time; a final digit is followed by the flushed partial word
// and the zero padding words. The output register gives one result per cycle unless stalled.
// A write to a known register keeps in_ready_o low while the width divider runs.
// Reset loads exponent 1, one digit, one word, unpack, with the geometry ready.
// A stalled output holds the engine; the input queue keeps accepting until full.
//
// Top level of the Mersenne digit pack/unpack block.
// Depends on mdpu_pkg, mdpu_cfg, mdpu_front and mdpu_engine.
module mersenne_digit_pack_unpack #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [31:0]                         data_in_i,
  input  logic [5:0]                          width_in_i,
  input  logic                                last_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [31:0]                         data_out_o,
  output logic [5:0]                          width_out_o,
  output logic                                width_error_o,
  output logic                                last_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mdpu_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);

  mdpu_pkg::cfg_t    cfg;
  logic              restart;
  logic              head_valid;
  mdpu_pkg::item_t   head;
  logic              head_pop;
  mdpu_pkg::result_t result;

  // Registers and digit geometry.
  mdpu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  // Input queue.
  mdpu_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_in_i    (data_in_i),
    .width_in_i   (width_in_i),
    .last_in_i    (last_in_i),
    .direction_i  (cfg.direction),
    .hold_i       (cfg.busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (head_pop)
  );

  // Pack/unpack engine.
  mdpu_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .restart_i    (restart),
    .item_valid_i (head_valid),
    .item_i       (head),
    .item_pop_o   (head_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (result)
  );

  assign data_out_o    = result.data;
  assign width_out_o   = result.width;
  assign width_error_o = result.err;
  assign last_out_o    = result.last;

  // No item enters while the geometry is being derived.
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.busy |-> !in_ready_o)
    else $error("input accepted while the width divider is running");

  // A write to a known register must hold off the input on the next cycle.
  a_write_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o &&
     (cfg_index_i == mdpu_pkg::CFG_EXPONENT || cfg_index_i == mdpu_pkg::CFG_DIGIT_COUNT ||
      cfg_index_i == mdpu_pkg::CFG_WORD_TOTAL || cfg_index_i == mdpu_pkg::CFG_DIRECTION))
    |=> !in_ready_o)
    else $error("input ready right after a register write");

  // A width error result is a zero word that closes the residue.
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && width_error_o) |->
      (last_out_o && data_out_o == '0 && width_out_o == mdpu_pkg::WidthFull))
    else $error("malformed width error result");

endmodule
